// ===== sv/dq_pkg.sv =====
package dq_pkg;

    localparam int DEPTH = 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int DW = 32;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_DROP_FRONT = 3'd2;
    localparam logic [2:0] CMD_DROP_BACK  = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]           cmd;
        logic signed [DW-1:0] data_in;
    } in_word_t;

    typedef struct packed {
        logic signed [DW-1:0] data_out;
        logic [1:0]           status;
        logic                 last;
    } out_word_t;

endpackage

// ===== sv/double_ended_queue_unit.sv =====
// Double-ended queue of signed 32-bit words held in a 16-entry ring store.
// Commands enter through a queue-style port: a word is taken on a clock edge
// with push high and full low. Each word carries a command (push front, push
// back, drop front, drop back, dump) and a value used only by the pushes.
// Results leave through a second queue-style port: the oldest result is on
// result_word while empty is low and is taken on an edge with pop high.
// A push or drop gives one status word, passed through the command queue and
// then the result queue. A dump of N stored elements gives N words, front
// first, the last one marked, or one status word if the deque is empty; the
// words come one per cycle from the single read port of the store while the
// result queue has room; so do pushes and drops, at one command per cycle.
// Unknown command codes are taken and discarded without a result.
// A two-entry command queue lets the port keep taking words while the
// execution side works; a two-entry result queue decouples the consumer.
// When the consumer stalls, the result queue fills, execution pauses, and
// full rises once the command queue is full too. Reset empties both queues
// and the deque; stored values are not cleared and are never read unwritten.
module double_ended_queue_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dq_pkg::in_word_t  cmd_word,
    output logic              empty,
    input  logic              pop,
    output dq_pkg::out_word_t result_word
);
    import dq_pkg::*;

    logic     cq_valid;
    in_word_t cq_word;
    logic     cq_take;

    dq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd_word (cmd_word),
        .cq_valid (cq_valid),
        .cq_word  (cq_word),
        .cq_take  (cq_take)
    );

    dq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cq_valid    (cq_valid),
        .cq_word     (cq_word),
        .cq_take     (cq_take),
        .empty       (empty),
        .pop         (pop),
        .result_word (result_word)
    );

endmodule

// ===== sv/dq_ram.sv =====
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dq_front.sv =====
module dq_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  dq_pkg::in_word_t cmd_word,
    output logic             cq_valid,
    output dq_pkg::in_word_t cq_word,
    input  logic             cq_take
);
    import dq_pkg::*;

    in_word_t   mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic       accept;
    logic       enq;
    logic       deq;

    assign full   = (cnt_reg == 2'd2);
    assign accept = push && !full;
    // Codes outside the command set are taken and dropped here.
    assign enq    = accept && (cmd_word.cmd inside {[CMD_PUSH_FRONT:CMD_DUMP]});
    assign deq    = cq_take && (cnt_reg != 2'd0);

    assign cq_valid = (cnt_reg != 2'd0);
    assign cq_word  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = enq ? ~wr_reg : wr_reg;
        rd_next  = deq ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_reg] <= cmd_word;
        end
    end

endmodule

// ===== sv/dq_back.sv =====
module dq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cq_valid,
    input  dq_pkg::in_word_t  cq_word,
    output logic              cq_take,
    output logic              empty,
    input  logic              pop,
    output dq_pkg::out_word_t result_word
);
    import dq_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;

    out_word_t     omem_reg [2];
    logic [1:0]    ocnt_reg;
    logic          owr_reg;
    logic          ord_reg;

    logic          pop_ok;
    logic [2:0]    occ;
    logic          room;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] front_dec;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] back_addr;
    logic [SW-1:0] dump_sum;
    logic [AW-1:0] dump_addr;
    logic          dump_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [DW-1:0] ram_rdata;

    logic          imm_valid;
    logic [1:0]    imm_status;
    logic          owr_en;
    out_word_t     owr_word;

    assign pop_ok = pop && (ocnt_reg != 2'd0);
    assign occ    = {1'b0, ocnt_reg} + {2'b00, pend_reg};
    // Status words go straight into the result queue; a store read waits in pend_reg first.
    assign room   = (occ <= 3'd1) || (pop_ok && (occ <= 3'd2));

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    // Both sums stay below twice the depth, so one subtract wraps them.
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
    assign dump_sum  = SW'(front_reg) + SW'(idx_reg);
    assign dump_addr = (dump_sum >= SW'(DEPTH)) ? AW'(dump_sum - SW'(DEPTH)) : AW'(dump_sum);
    assign dump_last = ((idx_reg + CW'(1)) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cq_take        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = front_dec;
        ram_re         = 1'b0;
        imm_valid      = 1'b0;
        imm_status     = STAT_OK;
        case (state_reg)
            ST_RUN:
            begin
                if (cq_valid && !pend_reg && room)
                begin
                    cq_take = 1'b1;
                    case (cq_word.cmd)
                        CMD_PUSH_FRONT:
                        begin
                            imm_valid = 1'b1;
                            if (is_full)
                            begin
                                imm_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            imm_valid = 1'b1;
                            if (is_full)
                            begin
                                imm_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = back_addr;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DROP_FRONT:
                        begin
                            imm_valid = 1'b1;
                            if (is_empty)
                            begin
                                imm_status = STAT_EMPTY;
                            end
                            else
                            begin
                                front_next = (front_reg == AW'(DEPTH - 1)) ?
                                             '0 : front_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_DROP_BACK:
                        begin
                            imm_valid = 1'b1;
                            if (is_empty)
                            begin
                                imm_status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (is_empty)
                            begin
                                imm_valid  = 1'b1;
                                imm_status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_DUMP;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            imm_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (room)
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                    if (dump_last)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        pend_next      = ram_re;
        pend_last_next = ram_re && dump_last;
    end

    dq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cq_word.data_in),
        .re    (ram_re),
        .raddr (dump_addr),
        .rdata (ram_rdata)
    );

    // Read data from a dump and immediate status words never arrive together.
    always_comb
    begin
        owr_en = pend_reg || imm_valid;
        if (pend_reg)
        begin
            owr_word.data_out = ram_rdata;
            owr_word.status   = STAT_OK;
            owr_word.last     = pend_last_reg;
        end
        else
        begin
            owr_word.data_out = '0;
            owr_word.status   = imm_status;
            owr_word.last     = 1'b1;
        end
    end

    assign empty       = (ocnt_reg == 2'd0);
    assign result_word = omem_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            ocnt_reg      <= 2'd0;
            owr_reg       <= 1'b0;
            ord_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            ocnt_reg      <= ocnt_reg + {1'b0, owr_en} - {1'b0, pop_ok};
            if (owr_en)
            begin
                owr_reg <= ~owr_reg;
            end
            if (pop_ok)
            begin
                ord_reg <= ~ord_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (owr_en)
        begin
            omem_reg[owr_reg] <= owr_word;
        end
    end

endmodule
